// ===== rtl/kmas_pkg.sv =====
// kmas_pkg: shared types and codes of the keyword mixed-alphabet substitution core
// used by kmas_walk and keyed_mixed_alphabet_substitution_core; no dependencies
`default_nettype none

package kmas_pkg;

    localparam int SYM_W = 8;
    localparam int CNT_W = 9;
    localparam int MODE_W = 3;
    localparam int STAT_W = 3;

    localparam logic [CNT_W-1:0] ALPHA_SIZE_RST = 9'd26;

    localparam logic [MODE_W-1:0] MODE_APPEND = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_BUILD  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ENCODE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_DECODE = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STAT_W-1:0] STAT_KEY_EMPTY = 3'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE     = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_BUILT = 3'd3;
    localparam logic [STAT_W-1:0] STAT_KEY_LONG  = 3'd4;

    localparam logic CFG_ALPHA_SIZE = 1'b0;
    localparam logic CFG_ARRANGE    = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_LOOKUP,
        ST_CLEAR,
        ST_KEYRD,
        ST_KEYCHK,
        ST_KEYMARK,
        ST_ALPHA,
        ST_ALPHAW,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic             go;
        logic [CNT_W-1:0] stride;
        logic [CNT_W-1:0] len;
    } t_walk_cmd;

    typedef struct packed {
        logic             act;
        logic [CNT_W-1:0] addr;
        logic [CNT_W-1:0] idx;
    } t_walk_out;

endpackage

`default_nettype wire

// ===== rtl/keyed_mixed_alphabet_substitution_core.sv =====
// keyed_mixed_alphabet_substitution_core: top level, sequencer, key store and tables
// uses kmas_pkg, kmas_ram, kmas_walk
//
//  channel   signals                                        direction  transfer when
//  item      start, busy, i_mode, i_symbol                  in         start && !busy
//  result    o_done, o_result_symbol, o_status              out        o_done (one cycle)
//  config    i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data  in     i_cfg_valid && o_cfg_ready
//
// append, clear, unused codes: result set in EXEC; encode, decode: in LOOKUP after a table read
// build: a clearing pass over n seen marks (n: alphabet size capped at ALPHA_MAX), then KEYRD,
// KEYCHK and KEYMARK per key symbol, ALPHA and ALPHAW per alphabet symbol, then the stride walk
// a key symbol outside the alphabet ends a build early with its status
// busy stays high from transfer until the result strobe; config is taken only while not busy
// the receiver cannot stall; every build clears its seen marks, no clearing pass after reset
`default_nettype none

module keyed_mixed_alphabet_substitution_core #(
    parameter int KEY_MAX   = 32,
    parameter int ALPHA_MAX = 256
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [kmas_pkg::MODE_W-1:0] i_mode,
    input  wire logic [kmas_pkg::SYM_W-1:0]  i_symbol,
    output logic                             o_done,
    output logic      [kmas_pkg::SYM_W-1:0]  o_result_symbol,
    output logic      [kmas_pkg::STAT_W-1:0] o_status,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic [kmas_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
    localparam int KLW = $clog2(KEY_MAX + 1);
    localparam int AW  = $clog2(ALPHA_MAX);
    localparam logic [KLW-1:0] KEY_FULL = KLW'(KEY_MAX);
    localparam logic [kmas_pkg::CNT_W-1:0] AMAX = 9'(ALPHA_MAX);

    kmas_pkg::t_state r_state, n_state;

    logic [kmas_pkg::MODE_W-1:0] r_mode, n_mode;
    logic [kmas_pkg::SYM_W-1:0]  r_sym, n_sym;
    logic [kmas_pkg::CNT_W-1:0]  r_alpha_size, n_alpha_size;
    logic                        r_arrange, n_arrange;
    logic                        r_table_ready, n_table_ready;
    logic [KLW-1:0]              r_key_len, n_key_len;
    logic [KLW-1:0]              r_kidx, n_kidx;
    logic [kmas_pkg::CNT_W-1:0]  r_len, n_len;
    logic [kmas_pkg::CNT_W-1:0]  r_klen, n_klen;
    logic [kmas_pkg::CNT_W-1:0]  r_ai, n_ai;
    logic                        r_ev, n_ev;
    logic [kmas_pkg::CNT_W-1:0]  r_eidx, n_eidx;
    logic                        r_done, n_done;
    logic [kmas_pkg::SYM_W-1:0]  r_res, n_res;
    logic [kmas_pkg::STAT_W-1:0] r_status, n_status;

    logic [kmas_pkg::CNT_W-1:0]  w_n;
    logic                        w_cfg_wr;
    logic                        w_key_we;
    logic                        w_key_re;
    logic [kmas_pkg::SYM_W-1:0]  w_key_rdata;
    logic                        w_seq_we;
    logic [kmas_pkg::SYM_W-1:0]  w_seq_wdata;
    logic [kmas_pkg::SYM_W-1:0]  w_seq_rdata;
    logic                        w_tab_re;
    logic [kmas_pkg::SYM_W-1:0]  w_mix_rdata;
    logic [kmas_pkg::SYM_W-1:0]  w_inv_rdata;
    logic [AW-1:0]               w_seen_addr;
    logic                        w_seen_we;
    logic                        w_seen_wdata;
    logic                        w_seen_re;
    logic                        w_seen_rdata;
    kmas_pkg::t_walk_cmd         w_walk_cmd;
    kmas_pkg::t_walk_out         w_walk;

    assign w_n        = (r_alpha_size > AMAX) ? AMAX : r_alpha_size;
    assign busy       = (r_state != kmas_pkg::ST_IDLE);
    assign o_cfg_ready = !busy;
    assign w_cfg_wr   = i_cfg_valid && o_cfg_ready;

    // seen marks are addressed by key symbol while deduplicating, by counter otherwise
    assign w_seen_addr  = (r_state == kmas_pkg::ST_KEYCHK || r_state == kmas_pkg::ST_KEYMARK)
                        ? w_key_rdata[AW-1:0] : r_ai[AW-1:0];
    assign w_seen_wdata = (r_state == kmas_pkg::ST_KEYMARK);

    assign w_walk_cmd.go     = (r_state == kmas_pkg::ST_ALPHA) && (r_ai >= w_n);
    assign w_walk_cmd.stride = r_arrange ? r_klen : 9'd1;
    assign w_walk_cmd.len    = r_len;

    always_comb begin
        n_state       = r_state;
        n_mode        = r_mode;
        n_sym         = r_sym;
        n_alpha_size  = r_alpha_size;
        n_arrange     = r_arrange;
        n_table_ready = r_table_ready;
        n_key_len     = r_key_len;
        n_kidx        = r_kidx;
        n_len         = r_len;
        n_klen        = r_klen;
        n_ai          = r_ai;
        n_ev          = w_walk.act;
        n_eidx        = w_walk.idx;
        n_done        = 1'b0;
        n_res         = r_res;
        n_status      = r_status;
        w_key_we      = 1'b0;
        w_key_re      = 1'b0;
        w_seq_we      = 1'b0;
        w_seq_wdata   = w_key_rdata;
        w_tab_re      = 1'b0;
        w_seen_we     = 1'b0;
        w_seen_re     = 1'b0;

        unique case (r_state)
            kmas_pkg::ST_IDLE: begin
                if (start) begin
                    n_mode  = i_mode;
                    n_sym   = i_symbol;
                    n_state = kmas_pkg::ST_EXEC;
                end
            end
            kmas_pkg::ST_EXEC: begin
                n_done   = 1'b1;
                n_res    = '0;
                n_status = kmas_pkg::STAT_OK;
                n_state  = kmas_pkg::ST_IDLE;
                unique case (r_mode)
                    kmas_pkg::MODE_APPEND: begin
                        if ({1'b0, r_sym} >= w_n) begin
                            n_status = kmas_pkg::STAT_RANGE;
                        end else if (r_key_len == KEY_FULL) begin
                            n_status = kmas_pkg::STAT_KEY_LONG;
                        end else begin
                            w_key_we  = 1'b1;
                            n_key_len = r_key_len + KLW'(1);
                        end
                    end
                    kmas_pkg::MODE_CLEAR: begin
                        n_key_len = '0;
                    end
                    kmas_pkg::MODE_BUILD: begin
                        if (r_key_len == '0) begin
                            n_status = kmas_pkg::STAT_KEY_EMPTY;
                        end else begin
                            n_done  = 1'b0;
                            n_ai    = '0;
                            n_kidx  = '0;
                            n_len   = '0;
                            n_state = kmas_pkg::ST_CLEAR;
                        end
                    end
                    kmas_pkg::MODE_ENCODE, kmas_pkg::MODE_DECODE: begin
                        if (!r_table_ready) begin
                            n_status = kmas_pkg::STAT_NOT_BUILT;
                        end else if ({1'b0, r_sym} >= w_n) begin
                            n_status = kmas_pkg::STAT_RANGE;
                        end else begin
                            n_done   = 1'b0;
                            w_tab_re = 1'b1;
                            n_state  = kmas_pkg::ST_LOOKUP;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            kmas_pkg::ST_LOOKUP: begin
                n_done   = 1'b1;
                n_status = kmas_pkg::STAT_OK;
                n_res    = (r_mode == kmas_pkg::MODE_ENCODE) ? w_mix_rdata : w_inv_rdata;
                n_state  = kmas_pkg::ST_IDLE;
            end
            kmas_pkg::ST_CLEAR: begin
                // only marks below the alphabet size are looked at by this build
                if (r_ai < w_n) begin
                    w_seen_we = 1'b1;
                    n_ai      = r_ai + 9'd1;
                end else begin
                    n_state = kmas_pkg::ST_KEYRD;
                end
            end
            kmas_pkg::ST_KEYRD: begin
                if (r_kidx != r_key_len) begin
                    w_key_re = 1'b1;
                    n_kidx   = r_kidx + KLW'(1);
                    n_state  = kmas_pkg::ST_KEYCHK;
                end else begin
                    n_klen  = r_len;
                    n_ai    = '0;
                    n_state = kmas_pkg::ST_ALPHA;
                end
            end
            kmas_pkg::ST_KEYCHK: begin
                if ({1'b0, w_key_rdata} >= w_n) begin
                    n_done   = 1'b1;
                    n_res    = '0;
                    n_status = kmas_pkg::STAT_RANGE;
                    n_state  = kmas_pkg::ST_IDLE;
                end else begin
                    w_seen_re = 1'b1;
                    n_state   = kmas_pkg::ST_KEYMARK;
                end
            end
            kmas_pkg::ST_KEYMARK: begin
                // key read data is held, so the symbol is still on w_key_rdata
                if (!w_seen_rdata) begin
                    w_seen_we = 1'b1;
                    w_seq_we  = 1'b1;
                    n_len     = r_len + 9'd1;
                end
                n_state = kmas_pkg::ST_KEYRD;
            end
            kmas_pkg::ST_ALPHA: begin
                if (r_ai < w_n) begin
                    w_seen_re = 1'b1;
                    n_state   = kmas_pkg::ST_ALPHAW;
                end else begin
                    n_state = kmas_pkg::ST_EMIT;
                end
            end
            kmas_pkg::ST_ALPHAW: begin
                w_seq_wdata = r_ai[kmas_pkg::SYM_W-1:0];
                if (!w_seen_rdata) begin
                    w_seq_we = 1'b1;
                    n_len    = r_len + 9'd1;
                end
                n_ai    = r_ai + 9'd1;
                n_state = kmas_pkg::ST_ALPHA;
            end
            kmas_pkg::ST_EMIT: begin
                if (!w_walk.act && !r_ev) begin
                    n_table_ready = 1'b1;
                    n_done        = 1'b1;
                    n_res         = '0;
                    n_status      = kmas_pkg::STAT_OK;
                    n_state       = kmas_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kmas_pkg::ST_IDLE;
            end
        endcase

        if (w_cfg_wr) begin
            unique case (i_cfg_index)
                kmas_pkg::CFG_ALPHA_SIZE: begin
                    n_alpha_size  = i_cfg_data;
                    n_table_ready = 1'b0;
                end
                kmas_pkg::CFG_ARRANGE: begin
                    n_arrange = i_cfg_data[0];
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= kmas_pkg::ST_IDLE;
            r_alpha_size  <= kmas_pkg::ALPHA_SIZE_RST;
            r_arrange     <= 1'b0;
            r_table_ready <= 1'b0;
            r_key_len     <= '0;
            r_ev          <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_alpha_size  <= n_alpha_size;
            r_arrange     <= n_arrange;
            r_table_ready <= n_table_ready;
            r_key_len     <= n_key_len;
            r_ev          <= n_ev;
            r_done        <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_sym    <= n_sym;
        r_kidx   <= n_kidx;
        r_len    <= n_len;
        r_klen   <= n_klen;
        r_ai     <= n_ai;
        r_eidx   <= n_eidx;
        r_res    <= n_res;
        r_status <= n_status;
    end

    kmas_ram #(
        .DEPTH (KEY_MAX),
        .WIDTH (kmas_pkg::SYM_W)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_key_len[KAW-1:0]),
        .i_wdata (r_sym),
        .i_re    (w_key_re),
        .i_raddr (r_kidx[KAW-1:0]),
        .o_rdata (w_key_rdata)
    );

    kmas_ram #(
        .DEPTH (ALPHA_MAX),
        .WIDTH (1)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (w_seen_we),
        .i_waddr (w_seen_addr),
        .i_wdata (w_seen_wdata),
        .i_re    (w_seen_re),
        .i_raddr (w_seen_addr),
        .o_rdata (w_seen_rdata)
    );

    kmas_ram #(
        .DEPTH (ALPHA_MAX),
        .WIDTH (kmas_pkg::SYM_W)
    ) u_seq (
        .i_clk   (i_clk),
        .i_we    (w_seq_we),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (w_seq_wdata),
        .i_re    (w_walk.act),
        .i_raddr (w_walk.addr[AW-1:0]),
        .o_rdata (w_seq_rdata)
    );

    // scatter: mixed[out] = seq[j] and inverse[seq[j]] = out in the same cycle
    kmas_ram #(
        .DEPTH (ALPHA_MAX),
        .WIDTH (kmas_pkg::SYM_W)
    ) u_mixed (
        .i_clk   (i_clk),
        .i_we    (r_ev),
        .i_waddr (r_eidx[AW-1:0]),
        .i_wdata (w_seq_rdata),
        .i_re    (w_tab_re),
        .i_raddr (r_sym[AW-1:0]),
        .o_rdata (w_mix_rdata)
    );

    kmas_ram #(
        .DEPTH (ALPHA_MAX),
        .WIDTH (kmas_pkg::SYM_W)
    ) u_inverse (
        .i_clk   (i_clk),
        .i_we    (r_ev),
        .i_waddr (w_seq_rdata[AW-1:0]),
        .i_wdata (r_eidx[kmas_pkg::SYM_W-1:0]),
        .i_re    (w_tab_re),
        .i_raddr (r_sym[AW-1:0]),
        .o_rdata (w_inv_rdata)
    );

    kmas_walk u_walk (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_walk_cmd),
        .o_walk  (w_walk)
    );

    assign o_done          = r_done;
    assign o_result_symbol = r_res;
    assign o_status        = r_status;

`ifndef SYNTH
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without an item in progress");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != kmas_pkg::STAT_OK) |-> (o_result_symbol == '0))
        else $error("nonzero symbol with an error status");

    a_walk_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_walk.act |-> (r_state == kmas_pkg::ST_EMIT))
        else $error("walker running outside the scatter phase");

    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_table_ready) |->
            ($past(w_cfg_wr && i_cfg_index == kmas_pkg::CFG_ALPHA_SIZE) || !$past(i_rst_n)))
        else $error("table lost without an alphabet size write");
`endif

endmodule

`default_nettype wire

// ===== rtl/kmas_ram.sv =====
// kmas_ram: simple dual-port memory, one write and one registered read per cycle
// no dependencies
`default_nettype none

module kmas_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/kmas_walk.sv =====
// kmas_walk: address walker that reads the sequence column by column with a stride
// uses kmas_pkg (walker command and status structs)
`default_nettype none

module kmas_walk (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire kmas_pkg::t_walk_cmd i_cmd,
    output kmas_pkg::t_walk_out     o_walk
);

    logic                       r_act, n_act;
    logic [kmas_pkg::CNT_W-1:0] r_j, n_j;
    logic [kmas_pkg::CNT_W-1:0] r_c, n_c;
    logic [kmas_pkg::CNT_W-1:0] r_out, n_out;
    logic [kmas_pkg::CNT_W-1:0] r_stride, n_stride;
    logic [kmas_pkg::CNT_W-1:0] r_len, n_len;
    logic [kmas_pkg::CNT_W:0]   w_sum;
    logic [kmas_pkg::CNT_W-1:0] w_cn;

    // row adder and column incrementer: next row in this column, or start of next column
    assign w_sum = {1'b0, r_j} + {1'b0, r_stride};
    assign w_cn  = r_c + 9'd1;

    always_comb begin
        n_act    = r_act;
        n_j      = r_j;
        n_c      = r_c;
        n_out    = r_out;
        n_stride = r_stride;
        n_len    = r_len;
        if (i_cmd.go) begin
            n_act    = 1'b1;
            n_j      = '0;
            n_c      = '0;
            n_out    = '0;
            n_stride = i_cmd.stride;
            n_len    = i_cmd.len;
        end else if (r_act) begin
            n_out = r_out + 9'd1;
            if (w_sum < {1'b0, r_len}) begin
                n_j = w_sum[kmas_pkg::CNT_W-1:0];
            end else if (w_cn == r_stride) begin
                n_act = 1'b0;
            end else begin
                n_j = w_cn;
                n_c = w_cn;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
        end else begin
            r_act <= n_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j      <= n_j;
        r_c      <= n_c;
        r_out    <= n_out;
        r_stride <= n_stride;
        r_len    <= n_len;
    end

    assign o_walk.act  = r_act;
    assign o_walk.addr = r_j;
    assign o_walk.idx  = r_out;

endmodule

`default_nettype wire

// ===== tb/sv/tb_keyed_mixed_alphabet_substitution_core.sv =====
// self-checking testbench for keyed_mixed_alphabet_substitution_core: directed and random items
// checked against a predictor of the key store and mixed/inverse tables; uses kmas_pkg
`timescale 1ns / 1ps

import kmas_pkg::*;

class cipher_scoreboard;
    localparam int KEY_DEPTH = 32;
    localparam int ALPHA_DEPTH = 256;
    localparam logic ARR_HORIZONTAL = 1'b0;
    localparam logic ARR_VERTICAL = 1'b1;

    int unsigned errors;
    int unsigned results_seen;
    logic [CNT_W-1:0] alpha_size;
    logic arrange;
    logic [SYM_W-1:0] key_mem [KEY_DEPTH];
    int key_len;
    logic [SYM_W-1:0] mix_tab [ALPHA_DEPTH];
    logic [SYM_W-1:0] inv_tab [ALPHA_DEPTH];
    bit tab_ready;
    logic [SYM_W-1:0] want_symbol [$];
    logic [STAT_W-1:0] want_status [$];

    function new();
        alpha_size = ALPHA_SIZE_RST;
        arrange = ARR_HORIZONTAL;
        key_len = 0;
        tab_ready = 1'b0;
        errors = 0;
        results_seen = 0;
    endfunction

    function int active_symbols();
        return (alpha_size > ALPHA_DEPTH) ? ALPHA_DEPTH : int'(alpha_size);
    endfunction

    function void write_register(logic idx, logic [CNT_W-1:0] data);
        if (idx == CFG_ALPHA_SIZE) begin
            alpha_size = data;
            tab_ready = 1'b0;
        end else begin
            arrange = data[0];
        end
    endfunction

    function logic [STAT_W-1:0] build_tables();
        int n;
        int len;
        int klen;
        int out_pos;
        logic [SYM_W-1:0] seq [ALPHA_DEPTH];
        bit seen [ALPHA_DEPTH];
        n = active_symbols();
        if (key_len == 0)
            return STAT_KEY_EMPTY;
        for (int i = 0; i < key_len; i++)
            if (int'(key_mem[i]) >= n)
                return STAT_RANGE;
        foreach (seen[i]) seen[i] = 1'b0;
        foreach (mix_tab[i]) mix_tab[i] = '0;
        foreach (inv_tab[i]) inv_tab[i] = '0;
        len = 0;
        klen = 0;
        // de-duplicated key first, then the rest of the alphabet in order
        for (int i = 0; i < key_len; i++) begin
            if (!seen[key_mem[i]]) begin
                seen[key_mem[i]] = 1'b1;
                seq[len] = key_mem[i];
                len++;
                klen++;
            end
        end
        for (int i = 0; i < n; i++) begin
            if (!seen[i]) begin
                seen[i] = 1'b1;
                seq[len] = 8'(i);
                len++;
            end
        end
        if (arrange == ARR_HORIZONTAL) begin
            for (int i = 0; i < len; i++)
                mix_tab[i] = seq[i];
        end else begin
            // read the sequence column by column, klen columns wide
            out_pos = 0;
            for (int c = 0; c < klen; c++) begin
                for (int j = c; j < len; j += klen) begin
                    mix_tab[out_pos] = seq[j];
                    out_pos++;
                end
            end
        end
        for (int i = 0; i < len; i++)
            inv_tab[mix_tab[i]] = 8'(i);
        tab_ready = 1'b1;
        return STAT_OK;
    endfunction

    function void note_item(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] sym);
        logic [SYM_W-1:0] res;
        logic [STAT_W-1:0] stat;
        int n;
        res = '0;
        stat = STAT_OK;
        n = active_symbols();
        case (mode)
            MODE_APPEND: begin
                if (int'(sym) >= n)
                    stat = STAT_RANGE;
                else if (key_len >= KEY_DEPTH)
                    stat = STAT_KEY_LONG;
                else begin
                    key_mem[key_len] = sym;
                    key_len++;
                end
            end
            MODE_CLEAR: key_len = 0;
            MODE_BUILD: stat = build_tables();
            MODE_ENCODE, MODE_DECODE: begin
                if (!tab_ready)
                    stat = STAT_NOT_BUILT;
                else if (int'(sym) >= n)
                    stat = STAT_RANGE;
                else
                    res = (mode == MODE_ENCODE) ? mix_tab[sym] : inv_tab[sym];
            end
            default: ;
        endcase
        want_symbol.push_back(res);
        want_status.push_back(stat);
    endfunction

    task report_mismatch(string msg);
        errors++;
        // keep the log short on a badly broken run
        if (errors <= 100)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task check_result(logic [SYM_W-1:0] sym, logic [STAT_W-1:0] stat);
        logic [SYM_W-1:0] exp_sym;
        logic [STAT_W-1:0] exp_stat;
        results_seen++;
        if (want_status.size() == 0) begin
            report_mismatch($sformatf("result with no item pending, status %0d symbol %0d",
                                      stat, sym));
        end else begin
            exp_sym = want_symbol.pop_front();
            exp_stat = want_status.pop_front();
            if (stat !== exp_stat)
                report_mismatch($sformatf("status got %0d want %0d", stat, exp_stat));
            if (sym !== exp_sym)
                report_mismatch($sformatf("result_symbol got %0d want %0d", sym, exp_sym));
        end
    endtask

    function int outstanding();
        return want_status.size();
    endfunction
endclass

module tb_keyed_mixed_alphabet_substitution_core;
    import kmas_pkg::*;

    localparam int LIMIT_CYCLES = 3_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int RANDOM_PHASES = 16;
    localparam int PHASE_ITEMS = 100;
    localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_LAST = 3'd7;
    localparam logic [SYM_W-1:0] KEYWORD [8] = '{8'd10, 8'd4, 8'd24, 8'd22,
                                                 8'd14, 8'd17, 8'd3, 8'd4};
    localparam logic [CNT_W-1:0] SIZE_PLAN [RANDOM_PHASES] = '{
        9'd2, 9'd256, 9'd5, 9'd0, 9'd26, 9'd1, 9'd511, 9'd8,
        9'd257, 9'd3, 9'd17, 9'd255, 9'd4, 9'd40, 9'd2, 9'd9};
    localparam int IDLE_PLAN [4] = '{0, 65, 0, 34};

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [MODE_W-1:0] i_mode;
    logic [SYM_W-1:0] i_symbol;
    logic o_done;
    logic [SYM_W-1:0] o_result_symbol;
    logic [STAT_W-1:0] o_status;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic i_cfg_index;
    logic [CNT_W-1:0] i_cfg_data;

    cipher_scoreboard sb;
    int idle_pct;
    int live_symbols;

    keyed_mixed_alphabet_substitution_core uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_mode          (i_mode),
        .i_symbol        (i_symbol),
        .o_done          (o_done),
        .o_result_symbol (o_result_symbol),
        .o_status        (o_status),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (LIMIT_CYCLES) @(posedge i_clk);
        $display("== FAIL ==");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_result_symbol, o_status);
    end

    function automatic logic [SYM_W-1:0] pick_symbol();
        // mostly inside the alphabet, now and then anything
        if (live_symbols == 0 || $urandom_range(0, 15) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, live_symbols - 1));
    endfunction

    // start stays high into the next call, so back-to-back items see one assignment per step
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SYM_W-1:0] sym);
        start <= 1'b1;
        i_mode <= mode;
        i_symbol <= sym;
        do @(posedge i_clk); while (busy);
        sb.note_item(mode, sym);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_register(idx, data);
    endtask

    task automatic configure(input logic [CNT_W-1:0] size, input logic arr);
        logic [CNT_W-1:0] arr_word;
        // upper bits of the arrangement word are don't-care
        arr_word = {8'($urandom_range(0, 255)), arr};
        drain();
        if ($urandom_range(0, 1)) begin
            write_reg(CFG_ALPHA_SIZE, size);
            write_reg(CFG_ARRANGE, arr_word);
        end else begin
            write_reg(CFG_ARRANGE, arr_word);
            write_reg(CFG_ALPHA_SIZE, size);
        end
        i_cfg_valid <= 1'b0;
        live_symbols = (size > 256) ? 256 : int'(size);
    endtask

    initial begin
        int sent;
        int k;
        int m;
        logic arr;
        sb = new();
        i_rst_n = 1'b0;
        start = 1'b0;
        i_mode = '0;
        i_symbol = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        idle_pct = 0;
        live_symbols = int'(ALPHA_SIZE_RST);
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: unbuilt table, empty key, out-of-range appends, a keyword with a repeat
        send_item(MODE_ENCODE, 8'd0);
        send_item(MODE_DECODE, 8'hFF);
        send_item(MODE_BUILD, 8'hFF);
        send_item(MODE_APPEND, 8'd26);
        send_item(MODE_APPEND, 8'hFF);
        foreach (KEYWORD[i]) send_item(MODE_APPEND, KEYWORD[i]);
        send_item(MODE_BUILD, 8'd0);
        send_item(MODE_ENCODE, 8'd0);
        send_item(MODE_ENCODE, 8'd25);
        send_item(MODE_ENCODE, 8'd26);
        send_item(MODE_DECODE, 8'd0);
        send_item(MODE_DECODE, 8'd25);
        send_item(MODE_DECODE, 8'hFF);
        send_item(MODE_SPARE_FIRST, 8'hFF);
        send_item(MODE_SPARE_LAST, 8'd0);
        // clearing the key leaves the built table usable
        send_item(MODE_CLEAR, 8'hFF);
        send_item(MODE_ENCODE, 8'd3);
        send_item(MODE_BUILD, 8'd0);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            arr = p[0] ^ (p >= RANDOM_PHASES / 2);
            configure(SIZE_PLAN[p], arr);
            idle_pct = IDLE_PLAN[p % 4];
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < 80) begin
                    // well-formed: (clear) key, build, then lookups; a kept key may be stale
                    if ($urandom_range(0, 3) != 0) begin
                        send_item(MODE_CLEAR, 8'($urandom_range(0, 255)));
                        sent++;
                    end
                    k = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 36)
                                                     : $urandom_range(1, 8);
                    repeat (k) begin
                        send_item(MODE_APPEND, pick_symbol());
                        sent++;
                    end
                    send_item(MODE_BUILD, 8'($urandom_range(0, 255)));
                    sent++;
                    m = $urandom_range(2, 12);
                    repeat (m) begin
                        send_item($urandom_range(0, 1) ? MODE_ENCODE : MODE_DECODE,
                                  pick_symbol());
                        sent++;
                    end
                end else begin
                    send_item(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
                    sent++;
                    if ($urandom_range(0, 19) == 0)
                        drain();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/kmas_pkg.sv
rtl/kmas_ram.sv
rtl/kmas_walk.sv
rtl/keyed_mixed_alphabet_substitution_core.sv
tb/sv/tb_keyed_mixed_alphabet_substitution_core.sv
